// ===== hw/rtl/rsdr_pkg.sv =====
package rsdr_pkg;

    localparam int LEVEL_W   = 8;
    localparam int NOW_W     = 7;
    localparam int MS_W      = 7;
    localparam int COUNT_W   = 4;
    localparam int TABLE_W   = 64;
    localparam int OUT_W     = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 64;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ENCODED   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEB_EN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEB_MS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PIN_COUNT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_VAL_TABLE = 3'd5;

    localparam logic [MS_W-1:0]    DEB_MS_RESET    = 7'd10;
    localparam logic [COUNT_W-1:0] PIN_COUNT_RESET = 4'd8;

    typedef struct packed {
        logic            invert;
        logic            debounce_en;
        logic [MS_W-1:0] debounce_ms;
    } lane_cfg_t;

endpackage

// ===== hw/rtl/rotary_switch_debounce_reader.sv =====
// An accepted scan's switch_value is registered in held_value_reg. Throughput:
// one scan per cycle unless the output stalls; all pins are handled by parallel
// lanes; in-use lanes (to the first active one in priority mode) update debounce on accept.
// Reset: all debounce state, the held value and the output register clear;
// registers take their defaults (debounce 10 ms, eight pins, value table zero).
module rotary_switch_debounce_reader #(
    parameter int PIN_COUNT_MAX = 8,
    parameter int TIME_BITS     = 7,
    parameter int VALUE_BITS    = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [rsdr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rsdr_pkg::CFG_W-1:0]        cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [rsdr_pkg::LEVEL_W-1:0]      pin_levels,
    input  logic [rsdr_pkg::NOW_W-1:0]        now_ms,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [rsdr_pkg::OUT_W-1:0]        switch_value
);
    import rsdr_pkg::*;

    logic                  encoded_reg;
    logic                  invert_reg;
    logic                  deb_en_reg;
    logic [MS_W-1:0]       deb_ms_reg;
    logic [COUNT_W-1:0]    pin_count_reg;
    logic [TABLE_W-1:0]    table_reg;

    logic                  out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]      held_value_reg, held_value_next;

    logic                  accept;
    lane_cfg_t             lane_cfg;
    logic [TIME_BITS-1:0]  now;
    logic [PIN_COUNT_MAX-1:0]            in_use;
    logic [PIN_COUNT_MAX-1:0]            on_eff;
    logic [PIN_COUNT_MAX-1:0]            upd;
    logic [PIN_COUNT_MAX-1:0]            level;
    logic [PIN_COUNT_MAX-1:0][OUT_W-1:0] values;
    logic [OUT_W-1:0]                    merged;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    assign lane_cfg.invert      = invert_reg;
    assign lane_cfg.debounce_en = deb_en_reg;
    assign lane_cfg.debounce_ms = deb_ms_reg;

    assign now = TIME_BITS'(now_ms);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            encoded_reg   <= 1'b0;
            invert_reg    <= 1'b0;
            deb_en_reg    <= 1'b0;
            deb_ms_reg    <= DEB_MS_RESET;
            pin_count_reg <= PIN_COUNT_RESET;
            table_reg     <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ENCODED:   encoded_reg   <= cfg_data[0];
                CFG_INVERT:    invert_reg    <= cfg_data[0];
                CFG_DEB_EN:    deb_en_reg    <= cfg_data[0];
                CFG_DEB_MS:    deb_ms_reg    <= cfg_data[MS_W-1:0];
                CFG_PIN_COUNT: pin_count_reg <= cfg_data[COUNT_W-1:0];
                CFG_VAL_TABLE: table_reg     <= cfg_data[TABLE_W-1:0];
                default:       ;
            endcase
        end
    end

    for (genvar i = 0; i < PIN_COUNT_MAX; i++)
    begin : g_lane
        logic [VALUE_BITS-1:0] slot;

        // pins past the level field read low
        if (i < LEVEL_W)
        begin : g_lvl
            assign level[i] = pin_levels[i];
        end
        else
        begin : g_nolvl
            assign level[i] = 1'b0;
        end

        for (genvar b = 0; b < VALUE_BITS; b++)
        begin : g_bit
            if (i * VALUE_BITS + b < TABLE_W)
            begin : g_in
                assign slot[b] = table_reg[i * VALUE_BITS + b];
            end
            else
            begin : g_out
                assign slot[b] = 1'b0;
            end
        end

        assign values[i] = OUT_W'(slot);
        assign in_use[i] = pin_count_reg > COUNT_W'(i);

        rsdr_lane #(
            .TIME_BITS (TIME_BITS)
        ) u_lane (
            .clk    (clk),
            .rst_n  (rst_n),
            .cfg    (lane_cfg),
            .level  (level[i]),
            .now    (now),
            .update (accept && upd[i]),
            .on_eff (on_eff[i])
        );
    end

    rsdr_merge #(
        .LANES (PIN_COUNT_MAX)
    ) u_merge (
        .encoded (encoded_reg),
        .in_use  (in_use),
        .on_eff  (on_eff),
        .values  (values),
        .held    (held_value_reg),
        .value   (merged),
        .upd     (upd)
    );

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        held_value_next = held_value_reg;
        if (accept)
        begin
            out_valid_next  = 1'b1;
            held_value_next = merged;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            held_value_reg <= '0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            held_value_reg <= held_value_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign switch_value = held_value_reg;

endmodule

// ===== hw/rtl/rsdr_lane.sv =====
module rsdr_lane #(
    parameter int TIME_BITS = 7
) (
    input  logic                clk,
    input  logic                rst_n,
    input  rsdr_pkg::lane_cfg_t cfg,
    input  logic                level,
    input  logic [TIME_BITS-1:0] now,
    input  logic                update,
    output logic                on_eff
);
    import rsdr_pkg::*;

    localparam int CMP_W = (TIME_BITS > MS_W) ? TIME_BITS : MS_W;

    logic                 accepted_reg, accepted_next;
    logic                 started_reg, started_next;
    logic [TIME_BITS-1:0] start_reg, start_next;
    logic                 on_raw;
    logic [TIME_BITS-1:0] elapsed;
    logic                 expired;

    assign on_raw  = level ^ cfg.invert;
    assign elapsed = now - start_reg;
    assign expired = CMP_W'(elapsed) > CMP_W'(cfg.debounce_ms);

    assign on_eff = cfg.debounce_en
                  ? (on_raw && (accepted_reg || (started_reg && expired)))
                  : on_raw;

    always_comb
    begin
        accepted_next = accepted_reg;
        started_next  = started_reg;
        start_next    = start_reg;
        if (update && cfg.debounce_en)
        begin
            if (!on_raw)
            begin
                accepted_next = 1'b0;
                started_next  = 1'b0;
                start_next    = '0;
            end
            else if (accepted_reg)
            begin
                accepted_next = 1'b1;
            end
            else if (!started_reg)
            begin
                started_next = 1'b1;
                start_next   = now;
            end
            else if (expired)
            begin
                accepted_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accepted_reg <= 1'b0;
            started_reg  <= 1'b0;
            start_reg    <= '0;
        end
        else
        begin
            accepted_reg <= accepted_next;
            started_reg  <= started_next;
            start_reg    <= start_next;
        end
    end

endmodule

// ===== hw/rtl/rsdr_merge.sv =====
module rsdr_merge #(
    parameter int LANES = 8
) (
    input  logic                                 encoded,
    input  logic [LANES-1:0]                     in_use,
    input  logic [LANES-1:0]                     on_eff,
    input  logic [LANES-1:0][rsdr_pkg::OUT_W-1:0] values,
    input  logic [rsdr_pkg::OUT_W-1:0]           held,
    output logic [rsdr_pkg::OUT_W-1:0]           value,
    output logic [LANES-1:0]                     upd
);
    import rsdr_pkg::*;

    logic [LANES-1:0] act;
    logic [OUT_W-1:0] value_or;
    logic [OUT_W-1:0] value_first;
    logic             any_lower;

    assign act = on_eff & in_use;

    // lanes above the first active pin keep their state in priority mode
    always_comb
    begin
        any_lower   = 1'b0;
        value_or    = '0;
        value_first = held;
        upd         = '0;
        for (int i = 0; i < LANES; i++)
        begin
            upd[i] = in_use[i] & (encoded | ~any_lower);
            if (act[i])
            begin
                value_or = value_or | values[i];
                if (!any_lower)
                    value_first = values[i];
            end
            any_lower = any_lower | act[i];
        end
    end

    assign value = encoded ? value_or : value_first;

endmodule
